### hdl/k_wgt_pkg.sv
// Shared constants, types and microcode program of the K-weighting filter.
package k_wgt_pkg;

    localparam int CHANNELS     = 8;
    localparam int FILTER_SLOTS = 5;
    localparam int SAMPLE_BITS  = 24;
    localparam int TAPS         = 4;

    localparam int CH_W      = 3;
    localparam int SLOT_W    = 3;
    localparam int MAP_W     = 24;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int HIST_W    = 48;
    localparam int HIST_FRAC = 40;
    localparam int COEF_W    = 35;
    localparam int HALF_W    = HIST_W / 2;
    localparam int PP_W      = COEF_W + HALF_W + 1;
    localparam int PROD_W    = PP_W + HALF_W;
    localparam int FLOOR_SH  = 28;
    localparam int TERM_W    = PROD_W - FLOOR_SH;
    localparam int ACC_W     = 58;
    localparam int OUT_W     = 32;
    localparam int OUT_SH    = 13;
    localparam int X_SHIFT   = HIST_FRAC + 1 - SAMPLE_BITS;
    localparam int NCOEF     = 9;
    localparam int STEP_W    = 5;

    localparam logic [MAP_W-1:0] MAP_RESET = 24'd180433;

    typedef logic [TAPS-1:0][HIST_W-1:0]  t_taps;
    typedef logic [NCOEF-1:0][COEF_W-1:0] t_coef_bank;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHELF_B0,
        CFG_SHELF_B1,
        CFG_SHELF_B2,
        CFG_FB_A1,
        CFG_FB_A2,
        CFG_FB_A3,
        CFG_FB_A4,
        CFG_SLOT_MAP
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LO,
        MUL_HI
    } t_mul_op;

    typedef enum logic [3:0] {
        CF_A1,
        CF_A2,
        CF_A3,
        CF_A4,
        CF_B0,
        CF_B1,
        CF_B2,
        CF_B3,
        CF_B4
    } t_coef_sel;

    typedef enum logic [2:0] {
        SR_V1,
        SR_V2,
        SR_V3,
        SR_V4,
        SR_W
    } t_src_sel;

    typedef enum logic {
        ACC_W_SUB,
        ACC_Y_ADD
    } t_acc_sel;

    typedef enum logic [1:0] {
        US_NEXT,
        US_JMP_UNUSED,
        US_END
    } t_seq_op;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_sq_state;

    typedef struct packed {
        t_seq_op             seq;
        logic [STEP_W-1:0]   target;
        t_mul_op             mul;
        t_coef_sel           coef;
        t_src_sel            src;
        t_acc_sel            acc;
        logic                sat_w;
    } t_uword;

    localparam logic [STEP_W-1:0] STEP_OUT = 5'd20;

    function automatic t_uword uw(input t_seq_op seq, input t_mul_op mul,
                                  input t_coef_sel coef, input t_src_sel src,
                                  input t_acc_sel acc, input logic sat_w);
        t_uword w;
        w.seq    = seq;
        w.target = STEP_OUT;
        w.mul    = mul;
        w.coef   = coef;
        w.src    = src;
        w.acc    = acc;
        w.sat_w  = sat_w;
        return w;
    endfunction

    function automatic t_uword urom(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            5'd0:  w = uw(US_JMP_UNUSED, MUL_LO, CF_A1, SR_V1, ACC_W_SUB, 1'b0);
            5'd1:  w = uw(US_NEXT, MUL_HI,   CF_A1, SR_V1, ACC_W_SUB, 1'b0);
            5'd2:  w = uw(US_NEXT, MUL_LO,   CF_A2, SR_V2, ACC_W_SUB, 1'b0);
            5'd3:  w = uw(US_NEXT, MUL_HI,   CF_A2, SR_V2, ACC_W_SUB, 1'b0);
            5'd4:  w = uw(US_NEXT, MUL_LO,   CF_A3, SR_V3, ACC_W_SUB, 1'b0);
            5'd5:  w = uw(US_NEXT, MUL_HI,   CF_A3, SR_V3, ACC_W_SUB, 1'b0);
            5'd6:  w = uw(US_NEXT, MUL_LO,   CF_A4, SR_V4, ACC_W_SUB, 1'b0);
            5'd7:  w = uw(US_NEXT, MUL_HI,   CF_A4, SR_V4, ACC_W_SUB, 1'b0);
            5'd8:  w = uw(US_NEXT, MUL_LO,   CF_B1, SR_V1, ACC_Y_ADD, 1'b0);
            5'd9:  w = uw(US_NEXT, MUL_HI,   CF_B1, SR_V1, ACC_Y_ADD, 1'b0);
            5'd10: w = uw(US_NEXT, MUL_LO,   CF_B2, SR_V2, ACC_Y_ADD, 1'b1);
            5'd11: w = uw(US_NEXT, MUL_HI,   CF_B2, SR_V2, ACC_Y_ADD, 1'b0);
            5'd12: w = uw(US_NEXT, MUL_LO,   CF_B0, SR_W,  ACC_Y_ADD, 1'b0);
            5'd13: w = uw(US_NEXT, MUL_HI,   CF_B0, SR_W,  ACC_Y_ADD, 1'b0);
            5'd14: w = uw(US_NEXT, MUL_LO,   CF_B3, SR_V3, ACC_Y_ADD, 1'b0);
            5'd15: w = uw(US_NEXT, MUL_HI,   CF_B3, SR_V3, ACC_Y_ADD, 1'b0);
            5'd16: w = uw(US_NEXT, MUL_LO,   CF_B4, SR_V4, ACC_Y_ADD, 1'b0);
            5'd17: w = uw(US_NEXT, MUL_HI,   CF_B4, SR_V4, ACC_Y_ADD, 1'b0);
            5'd18: w = uw(US_NEXT, MUL_NONE, CF_B4, SR_V4, ACC_Y_ADD, 1'b0);
            5'd19: w = uw(US_NEXT, MUL_NONE, CF_B4, SR_V4, ACC_Y_ADD, 1'b0);
            default: w = uw(US_END, MUL_NONE, CF_B4, SR_V4, ACC_Y_ADD, 1'b0);
        endcase
        return w;
    endfunction

endpackage

### hdl/k_wgt_useq.sv
// Microcode sequencer: step counter, program ROM and conditional jump.
module k_wgt_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_unused,
    input  logic              i_hold,
    output k_wgt_pkg::t_uword o_uw,
    output logic              o_busy,
    output logic              o_done
);

    k_wgt_pkg::t_sq_state            r_state;
    k_wgt_pkg::t_sq_state            n_state;
    logic [k_wgt_pkg::STEP_W-1:0]    r_step;
    logic [k_wgt_pkg::STEP_W-1:0]    n_step;
    k_wgt_pkg::t_uword               rom_word;

    assign rom_word = k_wgt_pkg::urom(r_step);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            k_wgt_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = k_wgt_pkg::ST_RUN;
                    n_step  = '0;
                end
            end
            k_wgt_pkg::ST_RUN: begin
                case (rom_word.seq)
                    k_wgt_pkg::US_NEXT: n_step = r_step + 1'b1;
                    k_wgt_pkg::US_JMP_UNUSED: begin
                        n_step = i_unused ? rom_word.target : r_step + 1'b1;
                    end
                    k_wgt_pkg::US_END: begin
                        if (!i_hold) begin
                            n_state = k_wgt_pkg::ST_IDLE;
                        end
                    end
                    default: n_step = r_step + 1'b1;
                endcase
            end
            default: n_state = k_wgt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy = 1'b0;
        o_done = 1'b0;
        o_uw   = k_wgt_pkg::urom(k_wgt_pkg::STEP_OUT);
        case (r_state)
            k_wgt_pkg::ST_RUN: begin
                o_busy = 1'b1;
                o_uw   = rom_word;
                o_done = (rom_word.seq == k_wgt_pkg::US_END) && !i_hold;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= k_wgt_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

### hdl/k_wgt_mac.sv
// Shared multiply-accumulate datapath: half-width products, floor, two accumulators.
module k_wgt_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  k_wgt_pkg::t_uword                      i_uw,
    input  logic                                   i_start,
    input  logic signed [k_wgt_pkg::SAMPLE_BITS-1:0] i_x,
    input  k_wgt_pkg::t_coef_bank                  i_coefs,
    input  k_wgt_pkg::t_taps                       i_taps,
    output logic        [k_wgt_pkg::HIST_W-1:0]    o_w,
    output logic signed [k_wgt_pkg::OUT_W-1:0]     o_y
);

    localparam int HW  = k_wgt_pkg::HALF_W;
    localparam int AW  = k_wgt_pkg::ACC_W;
    localparam int HSW = k_wgt_pkg::HIST_W;

    logic signed [k_wgt_pkg::COEF_W-1:0] coef;
    logic        [HSW-1:0]               src;
    logic signed [HW:0]                  half;
    logic signed [k_wgt_pkg::PP_W-1:0]   prod;
    logic signed [k_wgt_pkg::PP_W-1:0]   r_ppl;
    logic signed [k_wgt_pkg::PP_W-1:0]   r_pph;
    logic signed [k_wgt_pkg::PROD_W-1:0] sum;
    logic signed [k_wgt_pkg::PROD_W-1:0] r_prod;
    logic signed [k_wgt_pkg::TERM_W-1:0] term;
    logic signed [AW-1:0]                term_ext;
    logic signed [AW-1:0]                r_wacc;
    logic signed [AW-1:0]                r_yacc;
    logic        [HSW-1:0]               r_w;
    logic                                r_sum_vld;
    k_wgt_pkg::t_acc_sel                 r_sum_acc;
    logic                                r_acc_vld;
    k_wgt_pkg::t_acc_sel                 r_acc_sel;
    logic        [HSW-1:0]               w_sat;
    logic                                w_fits;
    logic                                y_fits;

    always_comb begin
        case (i_uw.coef)
            k_wgt_pkg::CF_A1: coef = i_coefs[k_wgt_pkg::CF_A1];
            k_wgt_pkg::CF_A2: coef = i_coefs[k_wgt_pkg::CF_A2];
            k_wgt_pkg::CF_A3: coef = i_coefs[k_wgt_pkg::CF_A3];
            k_wgt_pkg::CF_A4: coef = i_coefs[k_wgt_pkg::CF_A4];
            k_wgt_pkg::CF_B0: coef = i_coefs[k_wgt_pkg::CF_B0];
            k_wgt_pkg::CF_B1: coef = i_coefs[k_wgt_pkg::CF_B1];
            k_wgt_pkg::CF_B2: coef = i_coefs[k_wgt_pkg::CF_B2];
            k_wgt_pkg::CF_B3: coef = i_coefs[k_wgt_pkg::CF_B3];
            k_wgt_pkg::CF_B4: coef = i_coefs[k_wgt_pkg::CF_B4];
            default:          coef = '0;
        endcase
    end

    always_comb begin
        case (i_uw.src)
            k_wgt_pkg::SR_V1: src = i_taps[0];
            k_wgt_pkg::SR_V2: src = i_taps[1];
            k_wgt_pkg::SR_V3: src = i_taps[2];
            k_wgt_pkg::SR_V4: src = i_taps[3];
            k_wgt_pkg::SR_W:  src = r_w;
            default:          src = '0;
        endcase
    end

    always_comb begin
        case (i_uw.mul)
            k_wgt_pkg::MUL_HI: half = {src[HSW-1], src[HSW-1:HW]};
            default:           half = {1'b0, src[HW-1:0]};
        endcase
    end

    assign prod     = coef * half;
    assign sum      = $signed({r_pph, {HW{1'b0}}})
                    + $signed({{HW{r_ppl[k_wgt_pkg::PP_W-1]}}, r_ppl});
    assign term     = r_prod[k_wgt_pkg::PROD_W-1:k_wgt_pkg::FLOOR_SH];
    assign term_ext = {{(AW-k_wgt_pkg::TERM_W){term[k_wgt_pkg::TERM_W-1]}}, term};

    assign w_fits = (r_wacc[AW-1:HSW-1] == '0) || (r_wacc[AW-1:HSW-1] == '1);
    assign w_sat  = w_fits ? r_wacc[HSW-1:0]
                  : (r_wacc[AW-1] ? {1'b1, {(HSW-1){1'b0}}} : {1'b0, {(HSW-1){1'b1}}});

    localparam int YT = k_wgt_pkg::OUT_SH + k_wgt_pkg::OUT_W - 1;

    assign y_fits = (r_yacc[AW-1:YT] == '0) || (r_yacc[AW-1:YT] == '1);
    assign o_y    = y_fits ? r_yacc[YT:k_wgt_pkg::OUT_SH]
                  : (r_yacc[AW-1] ? {1'b1, {(k_wgt_pkg::OUT_W-1){1'b0}}}
                                  : {1'b0, {(k_wgt_pkg::OUT_W-1){1'b1}}});
    assign o_w    = r_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= 1'b0;
            r_acc_vld <= 1'b0;
        end else begin
            r_sum_vld <= (i_uw.mul == k_wgt_pkg::MUL_HI);
            r_acc_vld <= r_sum_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_acc <= i_uw.acc;
        r_acc_sel <= r_sum_acc;
        if (i_uw.mul == k_wgt_pkg::MUL_LO) begin
            r_ppl <= prod;
        end
        if (i_uw.mul == k_wgt_pkg::MUL_HI) begin
            r_pph <= prod;
        end
        if (r_sum_vld) begin
            r_prod <= sum;
        end
        if (i_uw.sat_w) begin
            r_w <= w_sat;
        end
        if (i_start) begin
            r_wacc <= {{(AW-k_wgt_pkg::SAMPLE_BITS-k_wgt_pkg::X_SHIFT){i_x[k_wgt_pkg::SAMPLE_BITS-1]}},
                       i_x, {k_wgt_pkg::X_SHIFT{1'b0}}};
            r_yacc <= '0;
        end else if (r_acc_vld) begin
            if (r_acc_sel == k_wgt_pkg::ACC_W_SUB) begin
                r_wacc <= r_wacc - term_ext;
            end else begin
                r_yacc <= r_yacc + term_ext;
            end
        end
    end

endmodule

### hdl/k_weighting_filter_with_peak.sv
// Top level: K-weighting filter with per-channel sample peak.
// A request on a channel mapped to a filter slot is accepted, then runs a
// 21-step microcode program driving a single shared 35x25-bit multiplier,
// two passes per coefficient product over nine products, then a three-stage
// combine, floor and accumulate pipeline; no new request is accepted until
// the program ends. On an unused channel the program jumps from its first
// step straight to its last. The result sits in an output register, so a
// new request is taken while the previous result waits; the program holds on
// its last step only when that register is still full and stalled. The user
// writes configuration through the plain write port while the block is idle; the block does not enforce it.
module k_weighting_filter_with_peak (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [k_wgt_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [k_wgt_pkg::CFG_W-1:0]               i_cfg_data,
    input  logic                                      i_in_valid,
    output logic                                      o_in_stall,
    input  logic [k_wgt_pkg::CH_W-1:0]                i_channel,
    input  logic signed [k_wgt_pkg::SAMPLE_BITS-1:0]  i_sample,
    output logic                                      o_out_valid,
    input  logic                                      i_out_stall,
    output logic signed [k_wgt_pkg::OUT_W-1:0]        o_filtered_sample,
    output logic                                      o_filtered_valid,
    output logic [k_wgt_pkg::SAMPLE_BITS-1:0]         o_channel_peak
);

    localparam int CW = k_wgt_pkg::COEF_W;
    localparam int SB = k_wgt_pkg::SAMPLE_BITS;

    function automatic logic signed [CW-1:0] sx(input logic [k_wgt_pkg::CFG_W-1:0] v);
        return {{(CW-k_wgt_pkg::CFG_W){v[k_wgt_pkg::CFG_W-1]}}, v};
    endfunction

    logic signed [CW-1:0]              r_s0, r_s1, r_s2;
    logic signed [CW-1:0]              r_b0, r_b1, r_b2, r_b3, r_b4;
    logic [k_wgt_pkg::CFG_W-1:0]       r_a1, r_a2, r_a3, r_a4;
    logic [k_wgt_pkg::MAP_W-1:0]       r_map;
    logic signed [CW-1:0]              d;
    k_wgt_pkg::t_coef_bank             coefs;

    logic [SB-1:0]                     r_peak [k_wgt_pkg::CHANNELS];
    k_wgt_pkg::t_taps                  r_hist [k_wgt_pkg::FILTER_SLOTS];
    k_wgt_pkg::t_taps                  r_taps;
    k_wgt_pkg::t_taps                  taps_new;

    logic                              in_accept;
    logic                              chan_ok;
    logic [k_wgt_pkg::SLOT_W-1:0]      slot;
    logic [k_wgt_pkg::SLOT_W-1:0]      row;
    logic                              used;
    logic [SB-1:0]                     mag;
    logic [SB-1:0]                     peak_cur;
    logic [SB-1:0]                     peak_new;

    logic                              r_used;
    logic [k_wgt_pkg::SLOT_W-1:0]      r_row;
    logic [SB-1:0]                     r_res_peak;

    logic                              r_out_vld;
    logic signed [k_wgt_pkg::OUT_W-1:0] r_out_y;
    logic                              r_out_fv;
    logic [SB-1:0]                     r_out_peak;

    k_wgt_pkg::t_uword                 uw;
    logic                              seq_busy;
    logic                              seq_done;
    logic                              hold;
    logic [k_wgt_pkg::HIST_W-1:0]      mac_w;
    logic signed [k_wgt_pkg::OUT_W-1:0] mac_y;

    assign in_accept = i_in_valid && !seq_busy;
    assign o_in_stall = seq_busy;
    assign hold = r_out_vld && i_out_stall;

    // Coefficient configuration, derived numerator kept alongside
    assign d = sx(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0  <= '0;
            r_s1  <= '0;
            r_s2  <= '0;
            r_b0  <= '0;
            r_b1  <= '0;
            r_b2  <= '0;
            r_b3  <= '0;
            r_b4  <= '0;
            r_a1  <= '0;
            r_a2  <= '0;
            r_a3  <= '0;
            r_a4  <= '0;
            r_map <= k_wgt_pkg::MAP_RESET;
        end else if (i_cfg_we) begin
            case (k_wgt_pkg::t_cfg_idx'(i_cfg_index))
                k_wgt_pkg::CFG_SHELF_B0: begin
                    r_s0 <= d;
                    r_b0 <= d;
                    r_b1 <= r_s1 - (d <<< 1);
                    r_b2 <= d - (r_s1 <<< 1) + r_s2;
                end
                k_wgt_pkg::CFG_SHELF_B1: begin
                    r_s1 <= d;
                    r_b1 <= d - (r_s0 <<< 1);
                    r_b2 <= r_s0 - (d <<< 1) + r_s2;
                    r_b3 <= d - (r_s2 <<< 1);
                end
                k_wgt_pkg::CFG_SHELF_B2: begin
                    r_s2 <= d;
                    r_b2 <= r_s0 - (r_s1 <<< 1) + d;
                    r_b3 <= r_s1 - (d <<< 1);
                    r_b4 <= d;
                end
                k_wgt_pkg::CFG_FB_A1:    r_a1  <= i_cfg_data;
                k_wgt_pkg::CFG_FB_A2:    r_a2  <= i_cfg_data;
                k_wgt_pkg::CFG_FB_A3:    r_a3  <= i_cfg_data;
                k_wgt_pkg::CFG_FB_A4:    r_a4  <= i_cfg_data;
                k_wgt_pkg::CFG_SLOT_MAP: r_map <= i_cfg_data[k_wgt_pkg::MAP_W-1:0];
                default: begin
                    r_map <= r_map;
                end
            endcase
        end
    end

    always_comb begin
        coefs                    = '0;
        coefs[k_wgt_pkg::CF_A1]  = sx(r_a1);
        coefs[k_wgt_pkg::CF_A2]  = sx(r_a2);
        coefs[k_wgt_pkg::CF_A3]  = sx(r_a3);
        coefs[k_wgt_pkg::CF_A4]  = sx(r_a4);
        coefs[k_wgt_pkg::CF_B0]  = r_b0;
        coefs[k_wgt_pkg::CF_B1]  = r_b1;
        coefs[k_wgt_pkg::CF_B2]  = r_b2;
        coefs[k_wgt_pkg::CF_B3]  = r_b3;
        coefs[k_wgt_pkg::CF_B4]  = r_b4;
    end

    // Request decode: peak update and slot lookup
    assign chan_ok  = int'(i_channel) < k_wgt_pkg::CHANNELS;
    assign slot     = r_map[i_channel*k_wgt_pkg::SLOT_W +: k_wgt_pkg::SLOT_W];
    assign row      = slot - 1'b1;
    assign used     = chan_ok && (slot != '0)
                   && (int'(slot) <= k_wgt_pkg::FILTER_SLOTS);
    assign mag      = i_sample[SB-1] ? (~i_sample + 1'b1) : i_sample;
    assign peak_cur = r_peak[i_channel];
    assign peak_new = (mag > peak_cur) ? mag : peak_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < k_wgt_pkg::CHANNELS; c++) begin
                r_peak[c] <= '0;
            end
        end else if (in_accept && chan_ok) begin
            r_peak[i_channel] <= peak_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (in_accept) begin
            r_used <= used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_row      <= row;
            r_res_peak <= chan_ok ? peak_new : '0;
            r_taps     <= used ? r_hist[row] : '0;
        end
    end

    // Write back shifted delay line
    always_comb begin
        taps_new    = r_taps;
        taps_new[3] = r_taps[2];
        taps_new[2] = r_taps[1];
        taps_new[1] = r_taps[0];
        taps_new[0] = mac_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < k_wgt_pkg::FILTER_SLOTS; s++) begin
                r_hist[s] <= '0;
            end
        end else if (seq_done && r_used) begin
            r_hist[r_row] <= taps_new;
        end
    end

    k_wgt_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_accept),
        .i_unused (!r_used),
        .i_hold   (hold),
        .o_uw     (uw),
        .o_busy   (seq_busy),
        .o_done   (seq_done)
    );

    k_wgt_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_uw    (uw),
        .i_start (in_accept),
        .i_x     (i_sample),
        .i_coefs (coefs),
        .i_taps  (r_taps),
        .o_w     (mac_w),
        .o_y     (mac_y)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (seq_done) begin
            r_out_vld <= 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_out_y    <= r_used ? mac_y : '0;
            r_out_fv   <= r_used;
            r_out_peak <= r_res_peak;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_filtered_sample = r_out_y;
    assign o_filtered_valid  = r_out_fv;
    assign o_channel_peak    = r_out_peak;

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(seq_done))
        else $error("result appeared without program completion");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_filtered_valid) |-> (o_filtered_sample == '0))
        else $error("unused channel result carries a nonzero sample");

    a_done_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_done |=> !seq_busy)
        else $error("sequencer still busy after completion");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (seq_busy && !o_out_valid) || (seq_busy && $past(r_out_vld)))
        else $error("accepted request did not start the program");

endmodule

### verif/testbench.sv
// Self-checking testbench for the K-weighting filter with per-channel sample peak.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import k_wgt_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0]   filtered;
        logic                      valid;
        logic [SAMPLE_BITS-1:0]    peak;
    } t_kw_result;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_TYPED,
        ROW_PREDICT
    } t_row_kind;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HALF,
        STALL_HEAVY
    } t_stall_mode;

    typedef struct packed {
        t_row_kind                      kind;
        t_cfg_idx                       idx;
        logic [CFG_W-1:0]               data;
        logic [CH_W-1:0]                ch;
        logic signed [SAMPLE_BITS-1:0]  smp;
        t_kw_result                     result;
    } t_dir_row;

    localparam int ITEMS_PER_PHASE = 108;
    localparam int N_PHASES        = 6;
    localparam int HOLD_AFTER      = 300;
    localparam int HOLD_CYCLES     = 400;

    localparam logic signed [127:0] W_MAX = (128'sd1 <<< (HIST_W - 1)) - 128'sd1;
    localparam logic signed [127:0] W_MIN = -(128'sd1 <<< (HIST_W - 1));
    localparam logic signed [127:0] Y_MAX = (128'sd1 <<< (OUT_W - 1)) - 128'sd1;
    localparam logic signed [127:0] Y_MIN = -(128'sd1 <<< (OUT_W - 1));

    localparam logic [CFG_W-1:0] KW_COEF [7] = '{
        32'sd412081942, -32'sd722546696, 32'sd321691121,
        -32'sd988032195, 32'sd1365543306, -32'sd840618069, 32'sd194671775
    };

    localparam int N_DIR = 28;
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{ROW_TYPED,   CFG_SHELF_B0, 32'd0, 3'd0, 24'sd0,      '{32'sd0, 1'b1, 24'd0}},
        '{ROW_TYPED,   CFG_SHELF_B0, 32'd0, 3'd0, 24'h7fffff,  '{32'sd0, 1'b1, 24'd8388607}},
        '{ROW_TYPED,   CFG_SHELF_B0, 32'd0, 3'd0, 24'h800000,  '{32'sd0, 1'b1, 24'd8388608}},
        '{ROW_TYPED,   CFG_SHELF_B0, 32'd0, 3'd0, 24'sd100,    '{32'sd0, 1'b1, 24'd8388608}},
        '{ROW_TYPED,   CFG_SHELF_B0, 32'd0, 3'd3, -24'sd5,     '{32'sd0, 1'b0, 24'd5}},
        '{ROW_TYPED,   CFG_SHELF_B0, 32'd0, 3'd6, 24'h800000,  '{32'sd0, 1'b0, 24'd8388608}},
        '{ROW_TYPED,   CFG_SHELF_B0, 32'd0, 3'd7, 24'sd1,      '{32'sd0, 1'b0, 24'd1}},
        '{ROW_TYPED,   CFG_SHELF_B0, 32'd0, 3'd1, -24'sd1,     '{32'sd0, 1'b1, 24'd1}},
        '{ROW_TYPED,   CFG_SHELF_B0, 32'd0, 3'd4, 24'h555555,  '{32'sd0, 1'b1, 24'd5592405}},
        '{ROW_TYPED,   CFG_SHELF_B0, 32'd0, 3'd5, 24'haaaaaa,  '{32'sd0, 1'b1, 24'd5592406}},
        '{ROW_CFG,     CFG_SHELF_B0, KW_COEF[0], 3'd0, 24'sd0, '0},
        '{ROW_CFG,     CFG_SHELF_B1, KW_COEF[1], 3'd0, 24'sd0, '0},
        '{ROW_CFG,     CFG_SHELF_B2, KW_COEF[2], 3'd0, 24'sd0, '0},
        '{ROW_CFG,     CFG_FB_A1,    KW_COEF[3], 3'd0, 24'sd0, '0},
        '{ROW_CFG,     CFG_FB_A2,    KW_COEF[4], 3'd0, 24'sd0, '0},
        '{ROW_CFG,     CFG_FB_A3,    KW_COEF[5], 3'd0, 24'sd0, '0},
        '{ROW_CFG,     CFG_FB_A4,    KW_COEF[6], 3'd0, 24'sd0, '0},
        '{ROW_PREDICT, CFG_SHELF_B0, 32'd0, 3'd2, 24'h7fffff,  '0},
        '{ROW_PREDICT, CFG_SHELF_B0, 32'd0, 3'd2, 24'sd0,      '0},
        '{ROW_PREDICT, CFG_SHELF_B0, 32'd0, 3'd2, 24'h800000,  '0},
        '{ROW_PREDICT, CFG_SHELF_B0, 32'd0, 3'd1, 24'sd4096,   '0},
        '{ROW_CFG,     CFG_SLOT_MAP, 32'h000000, 3'd0, 24'sd0, '0},
        '{ROW_TYPED,   CFG_SHELF_B0, 32'd0, 3'd2, 24'sd7,      '{32'sd0, 1'b0, 24'd8388608}},
        '{ROW_CFG,     CFG_SLOT_MAP, 32'hffffff, 3'd0, 24'sd0, '0},
        '{ROW_TYPED,   CFG_SHELF_B0, 32'd0, 3'd5, -24'sd1,     '{32'sd0, 1'b0, 24'd5592406}},
        '{ROW_CFG,     CFG_SLOT_MAP, 32'h249249, 3'd0, 24'sd0, '0},
        '{ROW_PREDICT, CFG_SHELF_B0, 32'd0, 3'd7, 24'h7fffff,  '0},
        '{ROW_PREDICT, CFG_SHELF_B0, 32'd0, 3'd0, 24'h800000,  '0}
    };

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [CFG_IDX_W-1:0]                i_cfg_index;
    logic [CFG_W-1:0]                    i_cfg_data;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic [CH_W-1:0]                     i_channel;
    logic signed [SAMPLE_BITS-1:0]       i_sample;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic signed [OUT_W-1:0]             o_filtered_sample;
    logic                                o_filtered_valid;
    logic [SAMPLE_BITS-1:0]              o_channel_peak;

    logic signed [CFG_W-1:0]             shelf_coef [3];
    logic signed [CFG_W-1:0]             fb_coef [TAPS];
    logic [MAP_W-1:0]                    slot_map;
    logic signed [HIST_W-1:0]            taps_hist [FILTER_SLOTS][TAPS];
    logic [SAMPLE_BITS-1:0]              peak_hold [CHANNELS];

    t_kw_result                          expected_results [$];
    int                                  n_accepted;
    int                                  n_errors;

    k_weighting_filter_with_peak dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_channel         (i_channel),
        .i_sample          (i_sample),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_filtered_sample (o_filtered_sample),
        .o_filtered_valid  (o_filtered_valid),
        .o_channel_peak    (o_channel_peak)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic logic signed [127:0] q28_product(input logic signed [127:0] coef,
                                                        input logic signed [127:0] hist);
        logic signed [127:0] prod;
        prod = coef * hist;
        return prod >>> FLOOR_SH;
    endfunction

    function automatic t_kw_result filter_sample(input logic [CH_W-1:0] ch,
                                                 input logic signed [SAMPLE_BITS-1:0] smp);
        t_kw_result res;
        logic signed [SAMPLE_BITS:0] sx;
        logic [SAMPLE_BITS-1:0] mag;
        logic [SLOT_W-1:0] slot;
        logic signed [127:0] s0, s1, s2, w, acc;
        logic signed [127:0] num [TAPS+1];
        int sl;
        res = '0;
        sx = smp;
        mag = SAMPLE_BITS'(sx < 0 ? -sx : sx);
        if (mag > peak_hold[ch])
            peak_hold[ch] = mag;
        res.peak = peak_hold[ch];
        slot = slot_map[SLOT_W*ch +: SLOT_W];
        if (slot >= 1 && slot <= FILTER_SLOTS) begin
            sl = int'(slot) - 1;
            s0 = shelf_coef[0];
            s1 = shelf_coef[1];
            s2 = shelf_coef[2];
            num[0] = s0;
            num[1] = s1 - 2 * s0;
            num[2] = s0 - 2 * s1 + s2;
            num[3] = s1 - 2 * s2;
            num[4] = s2;
            w = sx;
            w = w <<< X_SHIFT;
            for (int k = 0; k < TAPS; k++)
                w = w - q28_product(fb_coef[k], taps_hist[sl][k]);
            if (w > W_MAX)
                w = W_MAX;
            if (w < W_MIN)
                w = W_MIN;
            acc = q28_product(num[0], w);
            for (int k = 0; k < TAPS; k++)
                acc = acc + q28_product(num[k+1], taps_hist[sl][k]);
            acc = acc >>> OUT_SH;
            if (acc > Y_MAX)
                acc = Y_MAX;
            if (acc < Y_MIN)
                acc = Y_MIN;
            for (int k = TAPS - 1; k > 0; k--)
                taps_hist[sl][k] = taps_hist[sl][k-1];
            taps_hist[sl][0] = w[HIST_W-1:0];
            res.filtered = acc[OUT_W-1:0];
            res.valid = 1'b1;
        end
        return res;
    endfunction

    task automatic send_request(input logic [CH_W-1:0] ch,
                                input logic signed [SAMPLE_BITS-1:0] smp,
                                input logic typed, input t_kw_result typed_result);
        t_kw_result predicted;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_channel <= ch;
        i_sample <= smp;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = filter_sample(ch, smp);
        expected_results.push_back(typed ? typed_result : predicted);
        n_accepted++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SHELF_B0: shelf_coef[0] = data;
            CFG_SHELF_B1: shelf_coef[1] = data;
            CFG_SHELF_B2: shelf_coef[2] = data;
            CFG_FB_A1:    fb_coef[0] = data;
            CFG_FB_A2:    fb_coef[1] = data;
            CFG_FB_A3:    fb_coef[2] = data;
            CFG_FB_A4:    fb_coef[3] = data;
            CFG_SLOT_MAP: slot_map = data[MAP_W-1:0];
            default: ;
        endcase
    endtask

    initial begin
        int item;
        int n_burst;
        logic drained;
        logic [CFG_W-1:0] value;
        logic [CH_W-1:0] ch;
        logic signed [SAMPLE_BITS-1:0] smp;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_channel = '0;
        i_sample = '0;
        n_accepted = 0;
        n_errors = 0;
        drained = 1'b0;
        foreach (shelf_coef[k])
            shelf_coef[k] = '0;
        foreach (fb_coef[k])
            fb_coef[k] = '0;
        slot_map = MAP_RESET;
        foreach (taps_hist[s, k])
            taps_hist[s][k] = '0;
        foreach (peak_hold[c])
            peak_hold[c] = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            if (DIR_ROWS[r].kind == ROW_CFG)
                write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].data);
            else
                send_request(DIR_ROWS[r].ch, DIR_ROWS[r].smp,
                             DIR_ROWS[r].kind == ROW_TYPED, DIR_ROWS[r].result);
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            for (int r = 0; r < 8; r++) begin
                case (phase)
                    0: value = (r < 7) ? KW_COEF[r] : CFG_W'(MAP_RESET);
                    1: value = (r < 7) ? 32'h7fffffff : $urandom;
                    2: value = (r < 7) ? 32'h80000000 : 32'h249249;
                    3: value = $urandom;
                    4: value = (r < 7) ? CFG_W'(int'($urandom_range(0, 1 << 29)) - (1 << 28))
                                       : $urandom;
                    default: value = (r < 7) ? KW_COEF[r] : 32'o54321;
                endcase
                write_reg(t_cfg_idx'(r), value);
            end
            item = 0;
            while (item < ITEMS_PER_PHASE) begin
                n_burst = $urandom_range(1, 24);
                for (int b = 0; b < n_burst && item < ITEMS_PER_PHASE; b++) begin
                    ch = $urandom_range(0, CHANNELS - 1);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: smp = SAMPLE_BITS'($urandom);
                        5, 6: smp = SAMPLE_BITS'(int'($urandom_range(0, 8192)) - 4096);
                        7: smp = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
                        8: smp = '0;
                        default: smp = SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1);
                    endcase
                    send_request(ch, smp, 1'b0, '0);
                    item++;
                end
                if (phase == 2 && !drained && item >= 50) begin
                    drained = 1'b1;
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                    while (expected_results.size() != 0)
                        @(posedge i_clk);
                end
                repeat ($urandom_range(0, 12)) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                end
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_stall_mode mode;
        int seg;
        logic held;
        i_out_stall = 1'b0;
        held = 1'b0;
        forever begin
            if (!held && n_accepted >= HOLD_AFTER) begin
                held = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
            seg = $urandom_range(4, 60);
            mode = t_stall_mode'($urandom_range(0, 3));
            repeat (seg) begin
                @(negedge i_clk);
                case (mode)
                    STALL_NONE:  i_out_stall <= 1'b0;
                    STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HALF:  i_out_stall <= 1'($urandom_range(0, 1));
                    default:     i_out_stall <= ($urandom_range(0, 6) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_kw_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: filtered %0d valid %0b peak %0d",
                         $time, o_filtered_sample, o_filtered_valid, o_channel_peak);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_filtered_sample !== want.filtered) begin
                    $display("%0t filtered_sample mismatch: exp %0d act %0d",
                             $time, want.filtered, o_filtered_sample);
                    n_errors++;
                end
                if (o_filtered_valid !== want.valid) begin
                    $display("%0t filtered_valid mismatch: exp %0b act %0b",
                             $time, want.valid, o_filtered_valid);
                    n_errors++;
                end
                if (o_channel_peak !== want.peak) begin
                    $display("%0t channel_peak mismatch: exp %0d act %0d",
                             $time, want.peak, o_channel_peak);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
